>>> design/rotation_matrix_to_quaternion_unit_macros.svh
// Assertion macros for the rotation matrix to quaternion unit.
// Depends on a clock named clk and a reset named arst_n in the using scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rmq_pkg.sv
// Package for the rotation matrix to quaternion unit: widths, path codes, stage types.
// No dependencies.
`default_nettype none
package rmq_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int FW   = 20;  // field width
	localparam int DW   = 22;  // element sum / difference
	localparam int RW   = 34;  // radicand before scaling, signed
	localparam int RADW = 64;  // scaled radicand
	localparam int SW   = 32;  // square root
	localparam int RMW  = 36;  // square root partial remainder
	localparam int QDW  = 33;  // divisor 2*s
	localparam int NW   = 54;  // dividend / remainder
	localparam int QW   = 21;  // quotient bits kept
	localparam int NSQ  = SW;  // square root cells
	localparam int NDV  = QW;  // divide cells

	localparam logic [1:0] PATH_TRACE = 2'd0;
	localparam logic [1:0] PATH_X     = 2'd1;
	localparam logic [1:0] PATH_Y     = 2'd2;
	localparam logic [1:0] PATH_Z     = 2'd3;

	typedef struct packed {
		logic [RADW-1:0]           rad;
		logic [RMW-1:0]            rem;
		logic [SW-1:0]             res;
		logic signed [2:0][DW-1:0] d;
		logic [1:0]                path;
		logic                      bad;
	} sq_t;

	typedef struct packed {
		logic [QDW-1:0]       dd;
		logic [2:0][NW-1:0]   rem;
		logic [2:0][QW-1:0]   quo;
		logic [2:0]           neg;
		logic [2:0]           ovf;
		logic [SW-1:0]        s;
		logic [1:0]           path;
		logic                 bad;
	} dv_t;
endpackage
`default_nettype wire

>>> design/rmq_if.sv
// Handshake channels of the unit: matrix in and quaternion out.
// Depends on rmq_pkg for field widths.
`default_nettype none
interface rmq_mat_if;
	logic valid;
	logic ready;
	logic signed [rmq_pkg::FW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, input ready);
	modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33, output ready);
endinterface

interface rmq_quat_if;
	logic valid;
	logic ready;
	logic signed [rmq_pkg::FW-1:0] qx, qy, qz, qw;
	logic [1:0] path_taken;
	logic invalid;
	modport source (output valid, qx, qy, qz, qw, path_taken, invalid, input ready);
	modport sink (input valid, qx, qy, qz, qw, path_taken, invalid, output ready);
endinterface
`default_nettype wire

>>> design/rotation_matrix_to_quaternion_unit.sv
// Top level of the rotation matrix to quaternion unit (Shepperd branch method).
// Depends on rmq_pkg, rmq_if, rmq_sqrt_cell, rmq_div_cell and the macros header.
//
//  channel | dir | beat contents
//  mat     | in  | m11 m12 m13 m21 m22 m23 m31 m32 m33, 20 bit signed
//  quat    | out | qx qy qz qw 20 bit signed, path_taken 2 bit, invalid 1 bit
//
// One matrix per cycle while the output is taken; the stages are one setup stage, 32 square
// root cells, one divide setup stage, 21 divide cells and the output register.
// Every stage holds its own valid bit, so bubbles close up under a stall and a
// new beat is taken whenever any stage ahead has room.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none
`include "rotation_matrix_to_quaternion_unit_macros.svh"
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF  // 8 to 30
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rmq_mat_if.sink   mat,
	rmq_quat_if.source quat
);
	localparam int NS = 1 + rmq_pkg::NSQ + 1 + rmq_pkg::NDV + 1;
	localparam int ISQ = 1;                       // first square root stage
	localparam int IPR = 1 + rmq_pkg::NSQ;        // divide setup stage
	localparam int IDV = IPR + 1;                 // first divide stage
	localparam int IOUT = NS - 1;
	localparam logic signed [rmq_pkg::FW-1:0] QMAX = {1'b0, {(rmq_pkg::FW-1){1'b1}}};
	localparam logic signed [rmq_pkg::FW-1:0] QMIN = {1'b1, {(rmq_pkg::FW-1){1'b0}}};

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	// Ready ripples back: a stage has room when empty or when the next one moves.
	always_comb begin
		rdy[NS] = quat.ready;
		for (int i = NS-1; i >= 0; i--) rdy[i] = !vld_q[i] || rdy[i+1];
	end
	assign mat.ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= mat.valid;
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Setup: trace test, path choice, radicand and the three element terms.
	logic signed [rmq_pkg::RW-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
	logic signed [rmq_pkg::RW-1:0] one, trace, r;
	logic signed [rmq_pkg::RW-1:0] t0, t1, t2;
	rmq_pkg::sq_t setup;
	rmq_pkg::sq_t sq_s [rmq_pkg::NSQ+1];

	always_comb begin
		a11 = rmq_pkg::RW'(mat.m11); a12 = rmq_pkg::RW'(mat.m12); a13 = rmq_pkg::RW'(mat.m13);
		a21 = rmq_pkg::RW'(mat.m21); a22 = rmq_pkg::RW'(mat.m22); a23 = rmq_pkg::RW'(mat.m23);
		a31 = rmq_pkg::RW'(mat.m31); a32 = rmq_pkg::RW'(mat.m32); a33 = rmq_pkg::RW'(mat.m33);
		one   = rmq_pkg::RW'(1) <<< FRAC_BITS;
		trace = a11 + a22 + a33;
		if (trace > 0) begin
			setup.path = rmq_pkg::PATH_TRACE; r = trace + one;
			t0 = a23 - a32; t1 = a31 - a13; t2 = a12 - a21;
		end else if (a11 >= a22 && a11 >= a33) begin
			setup.path = rmq_pkg::PATH_X; r = one + a11 - a22 - a33;
			t0 = a12 + a21; t1 = a13 + a31; t2 = a23 - a32;
		end else if (a22 > a33) begin
			setup.path = rmq_pkg::PATH_Y; r = one + a22 - a11 - a33;
			t0 = a21 + a12; t1 = a32 + a23; t2 = a31 - a13;
		end else begin
			setup.path = rmq_pkg::PATH_Z; r = one + a33 - a11 - a22;
			t0 = a31 + a13; t1 = a32 + a23; t2 = a12 - a21;
		end
		setup.bad  = r <= 0;
		setup.rad  = setup.bad ? '0 : (rmq_pkg::RADW'(unsigned'(r)) << FRAC_BITS);
		setup.rem  = '0;
		setup.res  = '0;
		setup.d[0] = rmq_pkg::DW'(t0);
		setup.d[1] = rmq_pkg::DW'(t1);
		setup.d[2] = rmq_pkg::DW'(t2);
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) sq_s[0] <= setup;
	end

	// Square root chain, one root bit per cell.
	for (genvar g = 0; g < rmq_pkg::NSQ; g++) begin : g_sq
		rmq_sqrt_cell u_cell (.clk(clk), .en(rdy[ISQ+g]), .din(sq_s[g]), .dout(sq_s[g+1]));
	end

	// Divide setup: divisor 2*s, magnitudes, and the early overflow test.
	rmq_pkg::sq_t sq_end;
	rmq_pkg::dv_t prep;
	rmq_pkg::dv_t dv_s [rmq_pkg::NDV+1];
	logic [rmq_pkg::DW-1:0] mag [3];

	always_comb begin
		sq_end = sq_s[rmq_pkg::NSQ];
		prep.dd   = {sq_end.res, 1'b0};
		prep.s    = sq_end.res;
		prep.path = sq_end.path;
		prep.bad  = sq_end.bad;
		prep.quo  = '0;
		for (int l = 0; l < 3; l++) begin
			prep.neg[l] = sq_end.d[l][rmq_pkg::DW-1];
			mag[l] = prep.neg[l] ? rmq_pkg::DW'(-sq_end.d[l]) : rmq_pkg::DW'(sq_end.d[l]);
			prep.rem[l] = rmq_pkg::NW'(mag[l]) << FRAC_BITS;
			prep.ovf[l] = prep.rem[l] >= (rmq_pkg::NW'(prep.dd) << rmq_pkg::QW);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[IPR]) dv_s[0] <= prep;
	end

	// Divide chain, quotient bit 20 down to bit 0, all three lanes side by side.
	for (genvar g = 0; g < rmq_pkg::NDV; g++) begin : g_dv
		rmq_div_cell #(.K(rmq_pkg::NDV-1-g)) u_cell (
			.clk(clk), .en(rdy[IDV+g]), .din(dv_s[g]), .dout(dv_s[g+1]));
	end

	// Saturate, place the components by path, zero on a bad radicand.
	rmq_pkg::dv_t dv_end;
	logic signed [rmq_pkg::FW-1:0] oth [3];
	logic signed [rmq_pkg::FW-1:0] mainc, x_n, y_n, z_n, w_n;
	logic signed [rmq_pkg::FW-1:0] qx_q, qy_q, qz_q, qw_q;
	logic [1:0] path_q;
	logic       bad_q;

	always_comb begin
		dv_end = dv_s[rmq_pkg::NDV];
		for (int l = 0; l < 3; l++) begin
			if (dv_end.ovf[l]) begin
				oth[l] = dv_end.neg[l] ? QMIN : QMAX;
			end else if (dv_end.neg[l]) begin
				oth[l] = (dv_end.quo[l] > (rmq_pkg::QW'(1) << (rmq_pkg::FW-1))) ? QMIN
					: rmq_pkg::FW'(-dv_end.quo[l]);
			end else begin
				oth[l] = (dv_end.quo[l] > rmq_pkg::QW'(QMAX)) ? QMAX
					: rmq_pkg::FW'(dv_end.quo[l]);
			end
		end
		mainc = ((dv_end.s >> 1) > rmq_pkg::SW'(QMAX)) ? QMAX : rmq_pkg::FW'(dv_end.s >> 1);
		x_n = oth[0]; y_n = oth[1]; z_n = oth[2]; w_n = mainc;
		unique case (dv_end.path)
			rmq_pkg::PATH_TRACE: begin
				x_n = oth[0]; y_n = oth[1]; z_n = oth[2]; w_n = mainc;
			end
			rmq_pkg::PATH_X: begin
				x_n = mainc; y_n = oth[0]; z_n = oth[1]; w_n = oth[2];
			end
			rmq_pkg::PATH_Y: begin
				x_n = oth[0]; y_n = mainc; z_n = oth[1]; w_n = oth[2];
			end
			default: begin
				x_n = oth[0]; y_n = oth[1]; z_n = mainc; w_n = oth[2];
			end
		endcase
		if (dv_end.bad) begin
			x_n = '0; y_n = '0; z_n = '0; w_n = '0;
		end
	end

	// Output register: hold while the beat waits, refill as soon as it is taken.
	always_ff @(posedge clk) begin
		if (rdy[IOUT]) begin
			qx_q <= x_n; qy_q <= y_n; qz_q <= z_n; qw_q <= w_n;
			path_q <= dv_end.path;
			bad_q  <= dv_end.bad;
		end
	end

	assign quat.valid      = vld_q[IOUT];
	assign quat.qx         = qx_q;
	assign quat.qy         = qy_q;
	assign quat.qz         = qz_q;
	assign quat.qw         = qw_q;
	assign quat.path_taken = path_q;
	assign quat.invalid    = bad_q;

	`RMQ_ASSERT_NEXT(a_enter, mat.valid && mat.ready, vld_q[0], "accepted beat lost at entry")
	`RMQ_ASSERT_NOW(a_zero, quat.valid && quat.invalid,
		quat.qx == 0 && quat.qy == 0 && quat.qz == 0 && quat.qw == 0, "invalid beat not zero")
	`RMQ_ASSERT_NOW(a_trace, quat.valid && quat.path_taken == rmq_pkg::PATH_TRACE,
		!quat.invalid, "trace path flagged invalid")
endmodule
`default_nettype wire

>>> design/rmq_sqrt_cell.sv
// One square root cell: retires one root bit per beat.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_cell (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire rmq_pkg::sq_t din,
	output rmq_pkg::sq_t     dout
);
	logic [rmq_pkg::RMW-1:0] rem2, trial;
	logic ge;
	rmq_pkg::sq_t nxt;

	always_comb begin
		rem2  = {din.rem[rmq_pkg::RMW-3:0], din.rad[rmq_pkg::RADW-1 -: 2]};
		trial = {{(rmq_pkg::RMW-rmq_pkg::SW-2){1'b0}}, din.res, 2'b01};
		ge    = rem2 >= trial;
		nxt     = din;
		nxt.rad = {din.rad[rmq_pkg::RADW-3:0], 2'b00};
		nxt.rem = ge ? rem2 - trial : rem2;
		nxt.res = {din.res[rmq_pkg::SW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end
endmodule
`default_nettype wire

>>> design/rmq_div_cell.sv
// One restoring divide cell: one quotient bit per lane per beat.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div_cell #(
	parameter int K = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire rmq_pkg::dv_t din,
	output rmq_pkg::dv_t     dout
);
	logic [rmq_pkg::NW-1:0] dsh;
	logic [2:0] ge;
	rmq_pkg::dv_t nxt;

	always_comb begin
		dsh = rmq_pkg::NW'(din.dd) << K;
		nxt = din;
		for (int l = 0; l < 3; l++) begin
			ge[l] = din.rem[l] >= dsh;
			nxt.rem[l] = ge[l] ? din.rem[l] - dsh : din.rem[l];
			nxt.quo[l] = {din.quo[l][rmq_pkg::QW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end
endmodule
`default_nettype wire
